### src/apqm_pkg.sv
// apqm_pkg: types and codes shared by the priority queue controller, datapath and top level.
// Depends on nothing.
`default_nettype none

package apqm_pkg;

	localparam int KEY_W = 16;
	localparam int TAG_W = 32;
	localparam int OCC_W = 7;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_EXTRACTED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SHIFT
	} state_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] out_key;
		logic [TAG_W-1:0]        out_tag;
		logic [OCC_W-1:0]        occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	typedef struct packed {
		logic accept_ins;
		logic accept_empty;
		logic scan_init;
		logic scan_run;
		logic shift_init;
		logic shift_run;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic run_done;
	} sts_t;

endpackage

`default_nettype wire

### src/apqm_ctrl.sv
// apqm_ctrl: sequencer for the priority queue; decodes requests and steps the
// scan and shift passes of an extract. Depends on apqm_pkg.
`default_nettype none

module apqm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire apqm_pkg::op_t operation,
	input  wire apqm_pkg::sts_t sts,
	output apqm_pkg::cmd_t     cmd,
	output logic               busy
);

	apqm_pkg::state_t state_q;
	apqm_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apqm_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			apqm_pkg::FSM_IDLE: begin
				if (start && operation == apqm_pkg::OP_EXTRACT && !sts.empty) begin
					state_nxt = apqm_pkg::FSM_SCAN;
				end
			end
			apqm_pkg::FSM_SCAN: begin
				if (sts.run_done) begin
					state_nxt = apqm_pkg::FSM_SHIFT;
				end
			end
			apqm_pkg::FSM_SHIFT: begin
				if (sts.run_done) begin
					state_nxt = apqm_pkg::FSM_IDLE;
				end
			end
			default: state_nxt = apqm_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			apqm_pkg::FSM_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (operation == apqm_pkg::OP_INSERT) begin
						cmd.accept_ins = 1'b1;
					end else if (sts.empty) begin
						cmd.accept_empty = 1'b1;
					end else begin
						cmd.scan_init = 1'b1;
					end
				end
			end
			apqm_pkg::FSM_SCAN: begin
				cmd.scan_run   = 1'b1;
				cmd.shift_init = sts.run_done;
			end
			apqm_pkg::FSM_SHIFT: begin
				cmd.shift_run = 1'b1;
				cmd.finish    = sts.run_done;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

### src/apqm_dp.sv
// apqm_dp: entry memory, fill count, scan pointer, best-entry tracking and
// result register of the priority queue. Depends on apqm_pkg.
`default_nettype none

module apqm_dp #(
	parameter int CAPACITY = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire apqm_pkg::req_t req,
	input  wire apqm_pkg::cmd_t cmd,
	output apqm_pkg::sts_t      sts,
	output apqm_pkg::rsp_t      rsp,
	output logic                done
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	apqm_pkg::entry_t mem_q [CAPACITY];
	apqm_pkg::entry_t rd_data_q;
	apqm_pkg::entry_t wr_data;
	apqm_pkg::entry_t best_q;
	apqm_pkg::rsp_t   rsp_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] count_ins;
	logic [AW-1:0] ridx_q;
	logic [AW-1:0] best_idx_q;
	logic [AW-1:0] wr_addr;
	logic          rv_q;
	logic          first_q;
	logic          done_q;
	logic          full;
	logic          rd_en;
	logic          wr_en;
	logic          take_best;

	assign full      = (count_q == CW'(CAPACITY));
	assign count_ins = full ? count_q : count_q + CW'(1);
	assign rd_en     = (cmd.scan_run || cmd.shift_run) && (ptr_q < count_q);
	assign take_best = cmd.scan_run && rv_q &&
		(first_q || (rd_data_q.key > best_q.key));

	assign sts.empty    = (count_q == '0);
	assign sts.run_done = (ptr_q == count_q) && !rv_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = '{key: req.key, tag: req.tag};
		if (cmd.accept_ins && !full) begin
			wr_en = 1'b1;
		end else if (cmd.shift_run && rv_q) begin
			wr_en   = 1'b1;
			wr_addr = ridx_q - AW'(1);
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[ptr_q[AW-1:0]];
		end
		ridx_q <= ptr_q[AW-1:0];
		if (take_best) begin
			best_q     <= rd_data_q;
			best_idx_q <= ridx_q;
		end
		if (cmd.accept_ins) begin
			rsp_q.status    <= full ? apqm_pkg::ST_FULL : apqm_pkg::ST_INSERTED;
			rsp_q.out_key   <= '0;
			rsp_q.out_tag   <= '0;
			rsp_q.occupancy <= apqm_pkg::OCC_W'(count_ins);
		end else if (cmd.accept_empty) begin
			rsp_q.status    <= apqm_pkg::ST_EMPTY;
			rsp_q.out_key   <= '0;
			rsp_q.out_tag   <= '0;
			rsp_q.occupancy <= '0;
		end else if (cmd.finish) begin
			rsp_q.status    <= apqm_pkg::ST_EXTRACTED;
			rsp_q.out_key   <= best_q.key;
			rsp_q.out_tag   <= best_q.tag;
			rsp_q.occupancy <= apqm_pkg::OCC_W'(count_q - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			rv_q    <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.accept_ins || cmd.accept_empty || cmd.finish;
			rv_q   <= rd_en;
			if (cmd.scan_init) begin
				ptr_q <= '0;
			end else if (cmd.shift_init) begin
				ptr_q <= CW'(best_idx_q) + CW'(1);
			end else if (rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.scan_init) begin
				first_q <= 1'b1;
			end else if (cmd.scan_run && rv_q) begin
				first_q <= 1'b0;
			end
			if (cmd.accept_ins) begin
				count_q <= count_ins;
			end else if (cmd.accept_empty) begin
				count_q <= '0;
			end else if (cmd.finish) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

`default_nettype wire

### src/array_priority_queue_max_top.sv
// array_priority_queue_max_top: bounded max-priority queue in an unsorted array.
// Depends on apqm_pkg, apqm_ctrl and apqm_dp.
//
//   channel   handshake          payload
//   request   start, busy (out)  req  : apqm_pkg::req_t
//   result    done (out)         rsp  : apqm_pkg::rsp_t, one cycle, no back-pressure
//
// A request is taken at a clock edge with start high and busy low.
// Insert and extract-on-empty: result in the cycle after the request, busy stays low.
// Extract: a scan for the maximum over all entries, then a shift that closes the gap
// by moving each entry behind the maximum down one place; busy is high throughout, and
// the result is strobed as busy falls. The receiver cannot stall.
// Reset clears the fill count and control state; the memory needs no clearing.
`default_nettype none

module array_priority_queue_max_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire apqm_pkg::req_t req,
	output logic                done,
	output apqm_pkg::rsp_t      rsp
);

	apqm_pkg::cmd_t cmd;
	apqm_pkg::sts_t sts;

	apqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (req.operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	apqm_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

`default_nettype wire

### dv/array_priority_queue_max_top_tb.sv
// array_priority_queue_max_top_tb: self-checking bench for the max-priority queue top level.
// Drives insert and extract requests through start/busy and checks every strobed result
// against an in-bench queue predictor. Depends on apqm_pkg and array_priority_queue_max_top.
module array_priority_queue_max_top_tb;

	localparam int CAPACITY    = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASE_ITEMS = 160;

	typedef enum int {
		RUN_FILL,
		RUN_DRAIN,
		RUN_CHURN
	} run_kind_t;

	class max_queue_checker;
		int                                depth;
		logic signed [apqm_pkg::KEY_W-1:0] held_keys[$];
		logic [apqm_pkg::TAG_W-1:0]        held_tags[$];
		apqm_pkg::rsp_t                    pending_results[$];
		int                                failures;

		function new(int cap);
			depth = cap;
			failures = 0;
		endfunction

		function int held_count();
			return held_keys.size();
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void note_request(apqm_pkg::req_t r);
			apqm_pkg::rsp_t e;
			int best;
			e = '0;
			if (r.operation == apqm_pkg::OP_INSERT) begin
				if (held_keys.size() < depth) begin
					held_keys.push_back(r.key);
					held_tags.push_back(r.tag);
					e.status = apqm_pkg::ST_INSERTED;
				end else begin
					e.status = apqm_pkg::ST_FULL;
				end
			end else if (held_keys.size() == 0) begin
				e.status = apqm_pkg::ST_EMPTY;
			end else begin
				best = 0;
				for (int i = 1; i < held_keys.size(); i++)
					if (held_keys[i] > held_keys[best])
						best = i;
				e.status = apqm_pkg::ST_EXTRACTED;
				e.out_key = held_keys[best];
				e.out_tag = held_tags[best];
				held_keys.delete(best);
				held_tags.delete(best);
			end
			e.occupancy = apqm_pkg::OCC_W'(held_keys.size());
			pending_results.push_back(e);
		endfunction

		function void check_result(apqm_pkg::rsp_t got);
			apqm_pkg::rsp_t e;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: status %0d key %0d tag %h occ %0d",
						got.status, got.out_key, got.out_tag, got.occupancy);
				return;
			end
			e = pending_results.pop_front();
			if (got.status !== e.status || got.out_key !== e.out_key ||
					got.out_tag !== e.out_tag || got.occupancy !== e.occupancy) begin
				failures++;
				if (failures <= 10)
					$display({"mismatch: expected status %0d key %0d tag %h occ %0d,",
						" got status %0d key %0d tag %h occ %0d"},
						e.status, e.out_key, e.out_tag, e.occupancy,
						got.status, got.out_key, got.out_tag, got.occupancy);
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	apqm_pkg::req_t req = '0;
	logic           done;
	apqm_pkg::rsp_t rsp;
	int unsigned    cycle_count = 0;
	int             idle_pct = 0;

	max_queue_checker chk = new(CAPACITY);

	array_priority_queue_max_top #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			chk.check_result(rsp);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	function automatic logic signed [apqm_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return 16'sh0001;
				endcase
			end
			1: return apqm_pkg::KEY_W'(int'($urandom_range(0, 8)) - 4);
			default: return apqm_pkg::KEY_W'($urandom);
		endcase
	endfunction

	task automatic hold_off(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic issue(apqm_pkg::op_t op, logic signed [apqm_pkg::KEY_W-1:0] k,
			logic [apqm_pkg::TAG_W-1:0] t);
		apqm_pkg::req_t r;
		r.operation = op;
		r.key = k;
		r.tag = t;
		if ($urandom_range(0, 99) < idle_pct)
			hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(8, 140)
				: $urandom_range(1, 4));
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		chk.note_request(r);
	endtask

	task automatic issue_random(apqm_pkg::op_t op);
		issue(op, pick_key(), $urandom);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (chk.outstanding() != 0) @(posedge clk);
	endtask

	task automatic run_segment(run_kind_t kind, ref int sent);
		int n;
		case (kind)
			RUN_FILL: begin
				while (chk.held_count() < CAPACITY) begin
					issue_random(($urandom_range(0, 19) == 0) ? apqm_pkg::OP_EXTRACT
						: apqm_pkg::OP_INSERT);
					sent++;
				end
				n = $urandom_range(1, 3);
				repeat (n) begin
					issue_random(apqm_pkg::OP_INSERT);
					sent++;
				end
			end
			RUN_DRAIN: begin
				while (chk.held_count() > 0) begin
					issue_random(($urandom_range(0, 19) == 0) ? apqm_pkg::OP_INSERT
						: apqm_pkg::OP_EXTRACT);
					sent++;
				end
				n = $urandom_range(1, 3);
				repeat (n) begin
					issue_random(apqm_pkg::OP_EXTRACT);
					sent++;
				end
			end
			default: begin
				n = $urandom_range(10, 40);
				repeat (n) begin
					issue_random($urandom_range(0, 1) ? apqm_pkg::OP_EXTRACT
						: apqm_pkg::OP_INSERT);
					sent++;
				end
			end
		endcase
	endtask

	initial begin
		int idle_pcts[3];
		int sent;
		idle_pcts = '{22, 64, 0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_random(apqm_pkg::OP_EXTRACT);
		issue(apqm_pkg::OP_INSERT, 16'sh0000, 32'h0000_0000);
		issue(apqm_pkg::OP_INSERT, 16'sh7FFF, 32'hFFFF_FFFF);
		issue(apqm_pkg::OP_INSERT, 16'sh8000, 32'h0000_0001);
		issue(apqm_pkg::OP_INSERT, 16'sh7FFF, 32'h8000_0000);
		issue(apqm_pkg::OP_INSERT, 16'shFFFF, 32'h1234_5678);
		repeat (5) issue_random(apqm_pkg::OP_EXTRACT);
		issue_random(apqm_pkg::OP_EXTRACT);
		issue(apqm_pkg::OP_INSERT, 16'sh8000, 32'hA5A5_A5A5);
		issue(apqm_pkg::OP_INSERT, 16'sh8000, 32'h5A5A_5A5A);
		issue(apqm_pkg::OP_INSERT, 16'sh8000, 32'h0F0F_F0F0);
		repeat (4) issue_random(apqm_pkg::OP_EXTRACT);

		foreach (idle_pcts[p]) begin
			wait_drained();
			idle_pct = idle_pcts[p];
			sent = 0;
			while (sent < PHASE_ITEMS)
				run_segment(run_kind_t'($urandom_range(0, 2)), sent);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (chk.failures == 0 && chk.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
